[hdl/tok_pkg.sv]
// ----------------------------------------------------------------------------
// tok_pkg
// Shared types, constants and helper functions for the source tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package tok_pkg;

    localparam int MAX_IDENT_CHARS = 10;
    localparam int MAX_DIGITS      = 14;

    localparam int CHAR_W    = 8;
    localparam int KIND_W    = 5;
    localparam int VALUE_W   = 47;
    localparam int LEN_W     = 4;
    localparam int CNT_W     = 5;
    localparam int CHARS_W   = 80;
    localparam int BUF_AW    = (MAX_IDENT_CHARS > 1) ? $clog2(MAX_IDENT_CHARS) : 1;
    localparam int NUM_KW    = 8;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // scan modes
    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_WORD    = 3'd1;
    localparam logic [2:0] MODE_NUM     = 3'd2;
    localparam logic [2:0] MODE_COLON   = 3'd3;
    localparam logic [2:0] MODE_LESS    = 3'd4;
    localparam logic [2:0] MODE_GREATER = 3'd5;

    // token kinds
    localparam logic [KIND_W-1:0] TK_IDENT    = 5'd0;
    localparam logic [KIND_W-1:0] TK_NUMBER   = 5'd1;
    localparam logic [KIND_W-1:0] TK_PLUS     = 5'd2;
    localparam logic [KIND_W-1:0] TK_MINUS    = 5'd3;
    localparam logic [KIND_W-1:0] TK_TIMES    = 5'd4;
    localparam logic [KIND_W-1:0] TK_NUL      = 5'd5;
    localparam logic [KIND_W-1:0] TK_DIVIDE   = 5'd6;
    localparam logic [KIND_W-1:0] TK_LSS      = 5'd9;
    localparam logic [KIND_W-1:0] TK_LEQ      = 5'd10;
    localparam logic [KIND_W-1:0] TK_GTR      = 5'd11;
    localparam logic [KIND_W-1:0] TK_GEQ      = 5'd12;
    localparam logic [KIND_W-1:0] TK_LPAREN   = 5'd13;
    localparam logic [KIND_W-1:0] TK_RPAREN   = 5'd14;
    localparam logic [KIND_W-1:0] TK_COMMA    = 5'd15;
    localparam logic [KIND_W-1:0] TK_SEMI     = 5'd16;
    localparam logic [KIND_W-1:0] TK_LBRACKET = 5'd17;
    localparam logic [KIND_W-1:0] TK_RBRACKET = 5'd18;
    localparam logic [KIND_W-1:0] TK_LBRACE   = 5'd19;
    localparam logic [KIND_W-1:0] TK_RBRACE   = 5'd20;
    localparam logic [KIND_W-1:0] TK_BECOMES  = 5'd21;
    localparam logic [KIND_W-1:0] TK_IF       = 5'd22;
    localparam logic [KIND_W-1:0] TK_ELSE     = 5'd23;
    localparam logic [KIND_W-1:0] TK_WHILE    = 5'd24;
    localparam logic [KIND_W-1:0] TK_WRITE    = 5'd25;
    localparam logic [KIND_W-1:0] TK_READ     = 5'd26;
    localparam logic [KIND_W-1:0] TK_MAIN     = 5'd27;
    localparam logic [KIND_W-1:0] TK_INT      = 5'd28;
    localparam logic [KIND_W-1:0] TK_CHAR     = 5'd29;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
        logic               too_long;
        logic [63:0]        chars_low;
        logic [15:0]        chars_high;
        logic [LEN_W-1:0]   length;
        logic               last;
    } t_token;

    typedef struct packed {
        logic [1:0] count;
        t_token     first;
        t_token     second;
    } t_push;

    typedef struct packed {
        logic [CHARS_W-1:0] text;
        logic [LEN_W-1:0]   len;
        logic [KIND_W-1:0]  kind;
    } t_keyword;

    // keyword text packed first character in the low byte
    localparam t_keyword KEYWORDS [NUM_KW] = '{
        '{text: 80'h72616863,   len: 4'd4, kind: TK_CHAR},
        '{text: 80'h65736c65,   len: 4'd4, kind: TK_ELSE},
        '{text: 80'h6669,       len: 4'd2, kind: TK_IF},
        '{text: 80'h746e69,     len: 4'd3, kind: TK_INT},
        '{text: 80'h6e69616d,   len: 4'd4, kind: TK_MAIN},
        '{text: 80'h64616572,   len: 4'd4, kind: TK_READ},
        '{text: 80'h656c696877, len: 4'd5, kind: TK_WHILE},
        '{text: 80'h6574697277, len: 4'd5, kind: TK_WRITE}
    };

    function automatic logic [VALUE_W-1:0] f_sat_value();
        logic [VALUE_W-1:0] v;
        v = VALUE_W'(1);
        for (int i = 0; i < MAX_DIGITS; i++) begin
            v = VALUE_W'(v * VALUE_W'(10));
        end
        return v - VALUE_W'(1);
    endfunction

    localparam logic [VALUE_W-1:0] SAT_VALUE = f_sat_value();

    function automatic logic f_is_letter(input logic [CHAR_W-1:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic f_is_digit(input logic [CHAR_W-1:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [KIND_W-1:0] f_single_kind(input logic [CHAR_W-1:0] c);
        logic [KIND_W-1:0] k;
        unique case (c)
            "+":     k = TK_PLUS;
            "-":     k = TK_MINUS;
            "*":     k = TK_TIMES;
            "/":     k = TK_DIVIDE;
            "(":     k = TK_LPAREN;
            ")":     k = TK_RPAREN;
            ",":     k = TK_COMMA;
            ";":     k = TK_SEMI;
            "[":     k = TK_LBRACKET;
            "]":     k = TK_RBRACKET;
            "{":     k = TK_LBRACE;
            "}":     k = TK_RBRACE;
            "=":     k = TK_BECOMES;
            default: k = TK_NUL;
        endcase
        return k;
    endfunction

    function automatic t_token f_simple(input logic [KIND_W-1:0] kind);
        t_token t;
        t      = '0;
        t.kind = kind;
        return t;
    endfunction

endpackage

`default_nettype wire

[hdl/tok_if.sv]
// ----------------------------------------------------------------------------
// tok_if
// Valid/ready channels for source characters and for tokens.
// ----------------------------------------------------------------------------
`default_nettype none

interface tok_char_if;
    logic                      valid;
    logic                      ready;
    logic [tok_pkg::CHAR_W-1:0] char_code;
    logic                      end_of_input;

    modport source (output valid, char_code, end_of_input, input ready);
    modport sink   (input valid, char_code, end_of_input, output ready);
endinterface

interface tok_token_if;
    logic                       valid;
    logic                       ready;
    logic [tok_pkg::KIND_W-1:0]  token_kind;
    logic [tok_pkg::VALUE_W-1:0] number_value;
    logic                       number_too_long;
    logic [63:0]                ident_chars_low;
    logic [15:0]                ident_chars_high;
    logic [tok_pkg::LEN_W-1:0]   ident_length;
    logic                       last_of_run;

    modport source (output valid, token_kind, number_value, number_too_long,
                    ident_chars_low, ident_chars_high, ident_length, last_of_run,
                    input ready);
    modport sink   (input valid, token_kind, number_value, number_too_long,
                    ident_chars_low, ident_chars_high, ident_length, last_of_run,
                    output ready);
endinterface

`default_nettype wire

[hdl/source_tokenizer.sv]
// ----------------------------------------------------------------------------
// source_tokenizer
// Lexical analyser: one source character per request in, tokens out.
// ----------------------------------------------------------------------------
// Path: the first token of a character passes the input register and then
//   the result queue before it reaches the result port; a full queue stalls it.
// Throughput: one character per cycle while the queue has room; a character
//   giving two tokens leaves one at a time by the single-token result port.
// Reset: synchronous, active low; scanner idle, result queue empty.
`default_nettype none

module source_tokenizer (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    tok_char_if.sink    i_char,
    tok_token_if.source o_token
);

    tok_pkg::t_push push;
    logic           room;

    tok_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (i_char),
        .i_room  (room),
        .o_push  (push)
    );

    tok_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_token (o_token)
    );

endmodule

`default_nettype wire

[hdl/tok_scan.sv]
// ----------------------------------------------------------------------------
// tok_scan
// Input register and scanner: one character per cycle while i_room, up to two tokens out.
// ----------------------------------------------------------------------------
`default_nettype none

module tok_scan (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    tok_char_if.sink            i_char,
    input  wire logic           i_room,
    output tok_pkg::t_push      o_push
);

    logic                           r_in_valid;
    logic [tok_pkg::CHAR_W-1:0]     r_char;
    logic                           r_eoi;
    logic [2:0]                     r_mode;
    logic [tok_pkg::CHAR_W-1:0]     r_buf [tok_pkg::MAX_IDENT_CHARS];
    logic [tok_pkg::LEN_W-1:0]      r_len;
    logic [tok_pkg::VALUE_W-1:0]    r_acc;
    logic [tok_pkg::CNT_W-1:0]      r_cnt;

    logic [2:0]                     n_mode;
    logic [tok_pkg::LEN_W-1:0]      n_len;
    logic [tok_pkg::VALUE_W-1:0]    n_acc;
    logic [tok_pkg::CNT_W-1:0]      n_cnt;

    logic                           fire;
    logic                           buf_we;
    logic [tok_pkg::BUF_AW-1:0]     buf_wa;
    logic [tok_pkg::CHARS_W-1:0]    word_chars;
    logic                           is_kw;
    logic [tok_pkg::KIND_W-1:0]     kw_kind;
    tok_pkg::t_token                word_tok;
    tok_pkg::t_token                num_tok;
    tok_pkg::t_token                pend_tok;
    tok_pkg::t_token                a_tok;
    tok_pkg::t_token                b_tok;
    logic                           a_v;
    logic                           b_v;
    logic                           has_pend;
    logic                           is_eq;
    logic                           c_letter;
    logic                           c_digit;

    assign fire         = r_in_valid && i_room;
    assign i_char.ready = !r_in_valid || i_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_char.valid && i_char.ready) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.valid && i_char.ready) begin
            r_char <= i_char.char_code;
            r_eoi  <= i_char.end_of_input;
        end
    end

    // packed identifier, bytes past the length forced to zero
    always_comb begin
        word_chars = '0;
        for (int i = 0; i < tok_pkg::MAX_IDENT_CHARS; i++) begin
            if (tok_pkg::LEN_W'(i) < r_len) begin
                word_chars[8*i +: 8] = r_buf[i];
            end
        end
    end

    always_comb begin
        is_kw   = 1'b0;
        kw_kind = tok_pkg::TK_IDENT;
        for (int k = 0; k < tok_pkg::NUM_KW; k++) begin
            if (tok_pkg::KEYWORDS[k].len == r_len &&
                tok_pkg::KEYWORDS[k].text == word_chars) begin
                is_kw   = 1'b1;
                kw_kind = tok_pkg::KEYWORDS[k].kind;
            end
        end
    end

    always_comb begin
        if (is_kw) begin
            word_tok = tok_pkg::f_simple(kw_kind);
        end else begin
            word_tok            = tok_pkg::f_simple(tok_pkg::TK_IDENT);
            word_tok.chars_low  = word_chars[63:0];
            word_tok.chars_high = word_chars[79:64];
            word_tok.length     = r_len;
        end
        num_tok          = tok_pkg::f_simple(tok_pkg::TK_NUMBER);
        num_tok.value    = r_acc;
        num_tok.too_long = r_cnt > tok_pkg::CNT_W'(tok_pkg::MAX_DIGITS);
    end

    always_comb begin
        has_pend = 1'b1;
        unique case (r_mode)
            tok_pkg::MODE_WORD:    pend_tok = word_tok;
            tok_pkg::MODE_NUM:     pend_tok = num_tok;
            tok_pkg::MODE_COLON:   pend_tok = tok_pkg::f_simple(tok_pkg::TK_NUL);
            tok_pkg::MODE_LESS:    pend_tok = tok_pkg::f_simple(tok_pkg::TK_LSS);
            tok_pkg::MODE_GREATER: pend_tok = tok_pkg::f_simple(tok_pkg::TK_GTR);
            default: begin
                pend_tok = '0;
                has_pend = 1'b0;
            end
        endcase
    end

    assign c_letter = tok_pkg::f_is_letter(r_char);
    assign c_digit  = tok_pkg::f_is_digit(r_char);
    assign is_eq    = r_char == "=";

    always_comb begin
        n_mode = r_mode;
        n_len  = r_len;
        n_acc  = r_acc;
        n_cnt  = r_cnt;
        buf_we = 1'b0;
        buf_wa = '0;
        a_v    = 1'b0;
        b_v    = 1'b0;
        a_tok  = pend_tok;
        b_tok  = tok_pkg::f_simple(tok_pkg::f_single_kind(r_char));
        if (r_eoi) begin
            a_v    = has_pend;
            n_mode = tok_pkg::MODE_IDLE;
        end else if (r_mode == tok_pkg::MODE_WORD && (c_letter || c_digit)) begin
            if (r_len < tok_pkg::LEN_W'(tok_pkg::MAX_IDENT_CHARS)) begin
                buf_we = 1'b1;
                buf_wa = r_len[tok_pkg::BUF_AW-1:0];
                n_len  = r_len + tok_pkg::LEN_W'(1);
            end
        end else if (r_mode == tok_pkg::MODE_NUM && c_digit) begin
            if (r_cnt < tok_pkg::CNT_W'(tok_pkg::MAX_DIGITS)) begin
                // times ten as two shifts and an add
                n_acc = tok_pkg::VALUE_W'({r_acc, 3'b000} + {r_acc, 1'b0})
                        + tok_pkg::VALUE_W'(r_char[3:0]);
                n_cnt = r_cnt + tok_pkg::CNT_W'(1);
            end else begin
                n_acc = tok_pkg::SAT_VALUE;
                n_cnt = tok_pkg::CNT_W'(tok_pkg::MAX_DIGITS + 1);
            end
        end else if (is_eq && (r_mode == tok_pkg::MODE_COLON ||
                               r_mode == tok_pkg::MODE_LESS ||
                               r_mode == tok_pkg::MODE_GREATER)) begin
            a_v    = 1'b1;
            n_mode = tok_pkg::MODE_IDLE;
            priority if (r_mode == tok_pkg::MODE_COLON) begin
                a_tok = tok_pkg::f_simple(tok_pkg::TK_BECOMES);
            end else if (r_mode == tok_pkg::MODE_LESS) begin
                a_tok = tok_pkg::f_simple(tok_pkg::TK_LEQ);
            end else begin
                a_tok = tok_pkg::f_simple(tok_pkg::TK_GEQ);
            end
        end else begin
            // close whatever is pending, then start afresh on this character
            a_v    = has_pend;
            n_mode = tok_pkg::MODE_IDLE;
            priority if (r_char == " " || r_char == 8'h0a || r_char == 8'h09) begin
                n_mode = tok_pkg::MODE_IDLE;
            end else if (c_letter) begin
                n_mode = tok_pkg::MODE_WORD;
                buf_we = 1'b1;
                buf_wa = '0;
                n_len  = tok_pkg::LEN_W'(1);
            end else if (c_digit) begin
                n_mode = tok_pkg::MODE_NUM;
                n_acc  = tok_pkg::VALUE_W'(r_char[3:0]);
                n_cnt  = tok_pkg::CNT_W'(1);
            end else if (r_char == ":") begin
                n_mode = tok_pkg::MODE_COLON;
            end else if (r_char == "<") begin
                n_mode = tok_pkg::MODE_LESS;
            end else if (r_char == ">") begin
                n_mode = tok_pkg::MODE_GREATER;
            end else begin
                b_v = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= tok_pkg::MODE_IDLE;
            r_len  <= '0;
            r_acc  <= '0;
            r_cnt  <= '0;
        end else if (fire) begin
            r_mode <= n_mode;
            r_len  <= n_len;
            r_acc  <= n_acc;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && buf_we) begin
            r_buf[buf_wa] <= r_char;
        end
    end

    always_comb begin
        o_push             = '0;
        o_push.count       = fire ? ({1'b0, a_v} + {1'b0, b_v}) : 2'd0;
        o_push.first       = a_v ? a_tok : b_tok;
        o_push.first.last  = !(a_v && b_v);
        o_push.second      = b_tok;
        o_push.second.last = 1'b1;
    end

endmodule

`default_nettype wire

[hdl/tok_queue.sv]
// ----------------------------------------------------------------------------
// tok_queue
// Small result queue: takes up to two tokens a cycle, hands out one on ready.
// ----------------------------------------------------------------------------
`default_nettype none

module tok_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire tok_pkg::t_push i_push,
    output logic                o_room,
    tok_token_if.source         o_token
);

    tok_pkg::t_token              r_slot [tok_pkg::QUEUE_DEPTH];
    logic [tok_pkg::QPTR_W-1:0]   r_head;
    logic [tok_pkg::QPTR_W-1:0]   r_tail;
    logic [tok_pkg::QCNT_W-1:0]   r_count;

    logic                         pop;
    logic [tok_pkg::QPTR_W-1:0]   tail_next;
    tok_pkg::t_token              head;

    assign o_room    = r_count <= tok_pkg::QCNT_W'(tok_pkg::QUEUE_DEPTH - 2);
    assign pop       = o_token.valid && o_token.ready;
    assign tail_next = r_tail + tok_pkg::QPTR_W'(1);
    assign head      = r_slot[r_head];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_tail  <= r_tail + tok_pkg::QPTR_W'(i_push.count);
            r_count <= r_count + tok_pkg::QCNT_W'(i_push.count)
                       - tok_pkg::QCNT_W'(pop);
            if (pop) begin
                r_head <= r_head + tok_pkg::QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_slot[r_tail] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_slot[tail_next] <= i_push.second;
        end
    end

    assign o_token.valid            = r_count != '0;
    assign o_token.token_kind       = head.kind;
    assign o_token.number_value     = head.value;
    assign o_token.number_too_long  = head.too_long;
    assign o_token.ident_chars_low  = head.chars_low;
    assign o_token.ident_chars_high = head.chars_high;
    assign o_token.ident_length     = head.length;
    assign o_token.last_of_run      = head.last;

endmodule

`default_nettype wire

[hdl/tok_check.sv]
// ----------------------------------------------------------------------------
// tok_check
// Port-level checks on the tokenizer output, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tok_check (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_out_valid,
    input wire logic                        i_out_ready,
    input wire logic [tok_pkg::KIND_W-1:0]  i_kind,
    input wire logic [tok_pkg::VALUE_W-1:0] i_value,
    input wire logic                        i_too_long,
    input wire logic [63:0]                 i_chars_low,
    input wire logic [15:0]                 i_chars_high,
    input wire logic [tok_pkg::LEN_W-1:0]   i_length
);

    // queue empties on reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("token valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_kind) &&
            $stable(i_value) && $stable(i_chars_low) && $stable(i_length))
        else $error("stalled token changed");

    a_non_ident_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind != tok_pkg::TK_IDENT |->
            i_length == '0 && i_chars_low == '0 && i_chars_high == '0)
        else $error("identifier fields set on non-identifier token");

    a_ident_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind == tok_pkg::TK_IDENT |->
            i_length != '0 &&
            i_length <= tok_pkg::LEN_W'(tok_pkg::MAX_IDENT_CHARS))
        else $error("identifier length out of range");

    a_saturate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_too_long |->
            i_kind == tok_pkg::TK_NUMBER && i_value == tok_pkg::SAT_VALUE)
        else $error("overlong number not saturated");

endmodule

bind source_tokenizer tok_check u_tok_check (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_token.valid),
    .i_out_ready  (o_token.ready),
    .i_kind       (o_token.token_kind),
    .i_value      (o_token.number_value),
    .i_too_long   (o_token.number_too_long),
    .i_chars_low  (o_token.ident_chars_low),
    .i_chars_high (o_token.ident_chars_high),
    .i_length     (o_token.ident_length)
);

`default_nettype wire
